/* design/ppp_pkg.sv */
// Shared types and constants for the point perspective projection block.
package ppp_pkg;

  localparam int SCREEN_WIDTH  = 1024;
  localparam int SCREEN_HEIGHT = 1024;

  // Quotient bits produced by the divider chain, one per cell.
  localparam int DIV_BITS = 64;

  localparam int NUM_REGS = 7;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CAMERA_X = 3'd0,
    REG_CAMERA_Y = 3'd1,
    REG_CAMERA_Z = 3'd2,
    REG_CENTER_X = 3'd3,
    REG_CENTER_Y = 3'd4,
    REG_SCALE_X  = 3'd5,
    REG_SCALE_Y  = 3'd6
  } cfg_reg_t;

  // One beat travelling down the divider chain. The numerator shifts out at
  // the top of nq while quotient bits shift in at the bottom.
  typedef struct packed {
    logic        valid;
    logic        ok;
    logic        neg_x;
    logic        neg_y;
    logic [32:0] d_mag;
    logic [63:0] nq_x;
    logic [63:0] nq_y;
    logic [32:0] rem_x;
    logic [32:0] rem_y;
  } div_beat_t;

endpackage

/* design/point_perspective_project_top.sv */
// Top level of the point perspective projection pipeline.
//
//   channel  ports                                   handshake
//   input    in_point_x/y/z                          start high, busy low
//   result   out_pixel_x/y, out_visible              out_valid strobe, one cycle
//   config   cfg_we, cfg_index, cfg_wdata            write on cfg_we
//
// A point enters on every cycle; busy is always low. Each result passes
// through one multiply stage, one subtract stage, one divider cell per
// quotient bit, one saturation stage, one scale multiply stage and one
// output stage.
// Reset is synchronous and clears every valid bit in the pipeline and sets
// the registers to their defaults. The receiver cannot stall the results.
module point_perspective_project_top
  import ppp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   in_point_x,
  input  logic signed [31:0]   in_point_y,
  input  logic signed [31:0]   in_point_z,
  output logic                 out_valid,
  output logic signed [15:0]   out_pixel_x,
  output logic signed [15:0]   out_pixel_y,
  output logic                 out_visible,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  localparam int LATENCY = DIV_BITS + 5;

  // Configuration registers.
  logic signed [31:0] cam_x_r, cam_y_r, cam_z_r;
  logic signed [31:0] ctr_x_r, ctr_y_r, scl_x_r, scl_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_x_r <= '0;
      cam_y_r <= '0;
      cam_z_r <= 32'sd65536;
      ctr_x_r <= '0;
      ctr_y_r <= '0;
      scl_x_r <= 32'sd65536;
      scl_y_r <= 32'sd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CAMERA_X: cam_x_r <= cfg_wdata;
        REG_CAMERA_Y: cam_y_r <= cfg_wdata;
        REG_CAMERA_Z: cam_z_r <= cfg_wdata;
        REG_CENTER_X: ctr_x_r <= cfg_wdata;
        REG_CENTER_Y: ctr_y_r <= cfg_wdata;
        REG_SCALE_X:  scl_x_r <= cfg_wdata;
        REG_SCALE_Y:  scl_y_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline never holds a point back.
  assign busy = 1'b0;
  logic in_accept;
  assign in_accept = start && !busy;

  // Stage A: the four cross products and the divisor cz - z.
  logic               a_valid_r;
  logic               a_ok_r;
  logic signed [63:0] a_px1_r, a_px2_r, a_py1_r, a_py2_r;
  logic signed [32:0] a_d_r;
  logic signed [32:0] a_d_nxt;

  assign a_d_nxt = {cam_z_r[31], cam_z_r} - {in_point_z[31], in_point_z};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_accept;
    end
    a_ok_r    <= (cam_z_r != '0) && (a_d_nxt != '0);
    a_px1_r   <= in_point_x * cam_z_r;
    a_px2_r   <= cam_x_r * in_point_z;
    a_py1_r   <= in_point_y * cam_z_r;
    a_py2_r   <= cam_y_r * in_point_z;
    a_d_r     <= a_d_nxt;
  end

  // Stage B: exact numerators, then magnitudes and signs for the divider.
  logic signed [64:0] n_x, n_y;
  logic [64:0]        n_x_mag, n_y_mag;
  logic [32:0]        d_mag;
  div_beat_t          b_beat_nxt;
  div_beat_t          chain [0:DIV_BITS];

  always_comb begin
    n_x = {a_px1_r[63], a_px1_r} - {a_px2_r[63], a_px2_r};
    n_y = {a_py1_r[63], a_py1_r} - {a_py2_r[63], a_py2_r};
    n_x_mag = n_x[64] ? 65'(-n_x) : n_x;
    n_y_mag = n_y[64] ? 65'(-n_y) : n_y;
    d_mag = a_d_r[32] ? 33'(-a_d_r) : a_d_r;
    b_beat_nxt.valid = a_valid_r;
    b_beat_nxt.ok    = a_ok_r;
    b_beat_nxt.neg_x = n_x[64] ^ a_d_r[32];
    b_beat_nxt.neg_y = n_y[64] ^ a_d_r[32];
    b_beat_nxt.d_mag = d_mag;
    b_beat_nxt.nq_x  = n_x_mag[63:0];
    b_beat_nxt.nq_y  = n_y_mag[63:0];
    b_beat_nxt.rem_x = '0;
    b_beat_nxt.rem_y = '0;
    if (!rst_n) begin
      b_beat_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= b_beat_nxt;
  end

  // The divider: one cell per quotient bit, each passing its beat onward.
  for (genvar i = 0; i < DIV_BITS; i++) begin : g_cell
    ppp_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .beat_in  (chain[i]),
      .beat_out (chain[i+1])
    );
  end

  // Stage C: signed quotient saturated to 32 bits.
  div_beat_t          last;
  logic               c_valid_r, c_ok_r;
  logic signed [31:0] c_qx_r, c_qy_r;
  logic signed [31:0] c_qx_nxt, c_qy_nxt;

  assign last = chain[DIV_BITS];

  always_comb begin
    if (last.neg_x) begin
      c_qx_nxt = (last.nq_x > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-last.nq_x[31:0]);
    end else begin
      c_qx_nxt = (last.nq_x > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : last.nq_x[31:0];
    end
    if (last.neg_y) begin
      c_qy_nxt = (last.nq_y > 64'h8000_0000) ? 32'sh8000_0000 : 32'(-last.nq_y[31:0]);
    end else begin
      c_qy_nxt = (last.nq_y > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : last.nq_y[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
    end else begin
      c_valid_r <= last.valid;
    end
    c_ok_r    <= last.ok;
    c_qx_r    <= c_qx_nxt;
    c_qy_r    <= c_qy_nxt;
  end

  // Stage D: apply the scale factors.
  logic               d_valid_r, d_ok_r;
  logic signed [63:0] d_sx_r, d_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_valid_r <= 1'b0;
    end else begin
      d_valid_r <= c_valid_r;
    end
    d_ok_r    <= c_ok_r;
    d_sx_r    <= c_qx_r * scl_x_r;
    d_sy_r    <= c_qy_r * scl_y_r;
  end

  // Stage E: add the center, drop the fraction toward zero, saturate, clip.
  logic signed [64:0] s_x, s_y;
  logic signed [32:0] h_x, h_y;
  logic signed [15:0] p_x, p_y;
  logic               vis_nxt;
  logic               out_ok_r;

  always_comb begin
    s_x = {d_sx_r[63], d_sx_r} + {{17{ctr_x_r[31]}}, ctr_x_r, 16'b0};
    s_y = {d_sy_r[63], d_sy_r} + {{17{ctr_y_r[31]}}, ctr_y_r, 16'b0};
    h_x = s_x[64:32];
    h_y = s_y[64:32];
    // An arithmetic shift rounds down; a negative sum with a fraction moves
    // up by one to round toward zero instead.
    if (s_x[64] && (s_x[31:0] != '0)) begin
      h_x = 33'(h_x + 33'sd1);
    end
    if (s_y[64] && (s_y[31:0] != '0)) begin
      h_y = 33'(h_y + 33'sd1);
    end
    if (h_x > 33'sd32767) begin
      p_x = 16'sh7FFF;
    end else if (h_x < -33'sd32768) begin
      p_x = 16'sh8000;
    end else begin
      p_x = h_x[15:0];
    end
    if (h_y > 33'sd32767) begin
      p_y = 16'sh7FFF;
    end else if (h_y < -33'sd32768) begin
      p_y = 16'sh8000;
    end else begin
      p_y = h_y[15:0];
    end
    vis_nxt = d_ok_r && !p_x[15] && (p_x <= 16'(SCREEN_WIDTH))
              && !p_y[15] && (p_y <= 16'(SCREEN_HEIGHT));
    if (!d_ok_r) begin
      p_x = '0;
      p_y = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= d_valid_r;
    end
    out_ok_r    <= d_ok_r;
    out_pixel_x <= p_x;
    out_pixel_y <= p_y;
    out_visible <= vis_nxt;
  end

  // Every accepted point gives its result a fixed number of cycles later.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |-> ##LATENCY out_valid)
    else $error("result beat missing at the expected latency");

  // A zero divisor gives a zero pixel that is never visible.
  a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ok_r) |->
      (out_pixel_x == '0 && out_pixel_y == '0 && !out_visible))
    else $error("zero divisor result not cleared");

  // A visible pixel lies inside the screen.
  a_visible: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_visible) |->
      (!out_pixel_x[15] && !out_pixel_y[15]
       && out_pixel_x <= 16'(SCREEN_WIDTH) && out_pixel_y <= 16'(SCREEN_HEIGHT)))
    else $error("visible flag set outside the screen");

endmodule

/* design/ppp_div_cell.sv */
// One restoring-division cell: one quotient bit for each axis per beat.
module ppp_div_cell
  import ppp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  div_beat_t beat_in,
  output div_beat_t beat_out
);

  div_beat_t beat_nxt;
  div_beat_t beat_r;
  logic [33:0] trial_x;
  logic [33:0] trial_y;

  always_comb begin
    beat_nxt = beat_in;
    trial_x = {beat_in.rem_x, beat_in.nq_x[63]};
    trial_y = {beat_in.rem_y, beat_in.nq_y[63]};
    if (trial_x >= {1'b0, beat_in.d_mag}) begin
      beat_nxt.rem_x = 33'(trial_x - {1'b0, beat_in.d_mag});
      beat_nxt.nq_x  = {beat_in.nq_x[62:0], 1'b1};
    end else begin
      beat_nxt.rem_x = trial_x[32:0];
      beat_nxt.nq_x  = {beat_in.nq_x[62:0], 1'b0};
    end
    if (trial_y >= {1'b0, beat_in.d_mag}) begin
      beat_nxt.rem_y = 33'(trial_y - {1'b0, beat_in.d_mag});
      beat_nxt.nq_y  = {beat_in.nq_y[62:0], 1'b1};
    end else begin
      beat_nxt.rem_y = trial_y[32:0];
      beat_nxt.nq_y  = {beat_in.nq_y[62:0], 1'b0};
    end
    if (!rst_n) begin
      beat_nxt.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  assign beat_out = beat_r;

endmodule
